// ===== hw/rtl/load_cell_adc_reader_tare_scale_core_assert.svh =====
`ifndef LOAD_CELL_ADC_READER_TARE_SCALE_CORE_ASSERT_SVH
`define LOAD_CELL_ADC_READER_TARE_SCALE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCADC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcadc: same-cycle check failed");

// next-cycle implication, checked out of reset
`define LCADC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcadc: next-cycle check failed");

`endif

// ===== hw/rtl/lcadc_pkg.sv =====
package lcadc_pkg;

    // converter word and datapath widths
    localparam int CODE_BITS = 24;
    localparam int SUM_W     = 31;
    localparam int CNT_W     = 8;
    localparam int WEIGHT_W  = 41;
    localparam int DIV_NUM_W = 41;
    localparam int DIV_DEN_W = 24;
    localparam int FRAC_SH   = 16;

    localparam logic [CODE_BITS-1:0] SIGN_FLIP = 24'h800000;
    localparam logic [CNT_W-1:0]     AVG_MAX   = 8'd128;

    // configuration register indexes
    localparam logic [1:0] CFG_AVG_COUNT = 2'd0;
    localparam logic [1:0] CFG_SCALE_Q8  = 2'd1;

    // request kinds on s_tuser
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_MEASURE = 2'd1;
    localparam logic [1:0] FUNC_TARE    = 2'd2;

    // work handed from the front to the back
    typedef struct packed {
        logic             sck;
        logic             busy;
        logic             finish;
        logic             is_tare;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } job_t;

    // one result request
    typedef struct packed {
        logic                 sck_level;
        logic                 busy_res;
        logic                 result_valid;
        logic                 result_is_tare;
        logic [CODE_BITS-1:0] raw_average;
        logic [WEIGHT_W-1:0]  weight_q8;
        logic                 scale_error;
    } result_t;

endpackage

// ===== hw/rtl/lcadc_div.sv =====
module lcadc_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [lcadc_pkg::DIV_NUM_W-1:0]   num,
    input  logic [lcadc_pkg::DIV_DEN_W-1:0]   den,
    output logic                              busy,
    output logic                              done,
    output logic [lcadc_pkg::DIV_NUM_W-1:0]   quo
);
    import lcadc_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    // one restoring step per cycle, quotient bits shift in behind the numerator
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        rem_sub   = rem_sh - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIV_NUM_W-2:0], ge};
            rem_next  = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/lcadc_fifo.sv =====
module lcadc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lcadc_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output lcadc_pkg::job_t   pop_job,
    output logic              empty
);
    import lcadc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    job_t              slot_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job = slot_mem[rd_ptr_reg];
    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);

endmodule

// ===== hw/rtl/lcadc_front.sv =====
module lcadc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic [lcadc_pkg::CNT_W-1:0]   avg_count,
    input  logic                          q_full,
    output logic                          q_push,
    output lcadc_pkg::job_t               q_job
);
    import lcadc_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_WAIT = 3'd1;
    localparam logic [2:0] PH_HIGH = 3'd2;
    localparam logic [2:0] PH_LOW  = 3'd3;
    localparam logic [2:0] PH_GAIN = 3'd4;

    logic [2:0]           phase_reg, phase_next;
    logic [4:0]           bit_index_reg, bit_index_next;
    logic [CODE_BITS-1:0] code_shift_reg, code_shift_next;
    logic [CNT_W-1:0]     reads_done_reg, reads_done_next;
    logic [SUM_W-1:0]     code_sum_reg, code_sum_next;
    logic                 tare_pending_reg, tare_pending_next;

    logic                 accept;
    logic                 dt;
    logic [1:0]           func;
    logic                 finish;
    logic [CNT_W-1:0]     eff_count;
    logic [CODE_BITS-1:0] code_x;
    logic [SUM_W-1:0]     sum_add;
    logic [CNT_W-1:0]     rd_inc;

    assign accept   = s_tvalid && !q_full;
    assign s_tready = !q_full;
    assign dt       = s_tdata[0];
    assign func     = s_tuser;

    // clamp the averaging count to one..128
    always_comb begin
        if (avg_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (avg_count > AVG_MAX) begin
            eff_count = AVG_MAX;
        end else begin
            eff_count = avg_count;
        end
    end

    assign code_x  = code_shift_reg ^ SIGN_FLIP;
    assign sum_add = code_sum_reg + SUM_W'(code_x);
    assign rd_inc  = reads_done_reg + 1'b1;

    // bus sequencer, one step per accepted tick
    always_comb begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        code_shift_next   = code_shift_reg;
        reads_done_next   = reads_done_reg;
        code_sum_next     = code_sum_reg;
        tare_pending_next = tare_pending_reg;
        finish            = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_WAIT: begin
                    if (!dt) begin
                        phase_next      = PH_HIGH;
                        bit_index_next  = '0;
                        code_shift_next = '0;
                    end
                end
                PH_HIGH: begin
                    code_shift_next = {code_shift_reg[CODE_BITS-2:0], dt};
                    bit_index_next  = bit_index_reg + 1'b1;
                    phase_next      = PH_LOW;
                end
                PH_LOW: begin
                    phase_next = (bit_index_reg >= 5'(CODE_BITS)) ? PH_GAIN : PH_HIGH;
                end
                PH_GAIN: begin
                    code_sum_next   = sum_add;
                    reads_done_next = rd_inc;
                    if (rd_inc >= eff_count) begin
                        finish            = 1'b1;
                        phase_next        = PH_IDLE;
                        tare_pending_next = 1'b0;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end
                default: begin
                    // idle; unused codes are handled as idle
                    phase_next = PH_IDLE;
                    if (func == FUNC_MEASURE || func == FUNC_TARE) begin
                        phase_next        = PH_WAIT;
                        bit_index_next    = '0;
                        code_shift_next   = '0;
                        reads_done_next   = '0;
                        code_sum_next     = '0;
                        tare_pending_next = (func == FUNC_TARE);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= '0;
            code_shift_reg   <= '0;
            reads_done_reg   <= '0;
            code_sum_reg     <= '0;
            tare_pending_reg <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            code_shift_reg   <= code_shift_next;
            reads_done_reg   <= reads_done_next;
            code_sum_reg     <= code_sum_next;
            tare_pending_reg <= tare_pending_next;
        end
    end

    // every accepted tick becomes one queued job
    always_comb begin
        q_push        = accept;
        q_job.sck     = (phase_next == PH_HIGH) || (phase_next == PH_GAIN);
        q_job.busy    = (phase_next != PH_IDLE);
        q_job.finish  = finish;
        q_job.is_tare = tare_pending_reg;
        q_job.sum     = sum_add;
        q_job.count   = rd_inc;
    end

endmodule

// ===== hw/rtl/lcadc_back.sv =====
`include "load_cell_adc_reader_tare_scale_core_assert.svh"

module lcadc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    input  lcadc_pkg::job_t                   q_job,
    output logic                              q_pop,
    input  logic [lcadc_pkg::CODE_BITS-1:0]   scale_q8,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output lcadc_pkg::result_t                m_result
);
    import lcadc_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_AVG  = 2'd1;
    localparam logic [1:0] B_WT   = 2'd2;
    localparam logic [1:0] B_EMIT = 2'd3;

    logic [1:0]           st_reg, st_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              out_reg, out_next;
    result_t              res_reg, res_next;
    logic                 tare_reg, tare_next;
    logic                 neg_reg, neg_next;
    logic [CODE_BITS-1:0] offset_reg, offset_next;

    logic                 slot_free;
    logic                 load_out;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic [CODE_BITS-1:0] avg_q;
    logic [CODE_BITS:0]   diff;
    logic [CODE_BITS:0]   diff_mag;
    logic [CODE_BITS-1:0] scale_mag;

    lcadc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign slot_free = !m_valid_reg || m_tready;
    assign avg_q     = div_quo[CODE_BITS-1:0];
    assign diff      = {1'b0, avg_q} - {1'b0, offset_reg};
    assign diff_mag  = diff[CODE_BITS] ? (~diff + 1'b1) : diff;
    assign scale_mag = scale_q8[CODE_BITS-1] ? (~scale_q8 + 1'b1) : scale_q8;

    // result sequencer: plain ticks pass, finishes run one or two divides
    always_comb begin
        st_next     = st_reg;
        res_next    = res_reg;
        tare_next   = tare_reg;
        neg_next    = neg_reg;
        offset_next = offset_reg;
        out_next    = out_reg;
        q_pop       = 1'b0;
        load_out    = 1'b0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        unique case (st_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    if (q_job.finish) begin
                        q_pop     = 1'b1;
                        div_start = 1'b1;
                        div_num   = DIV_NUM_W'(q_job.sum);
                        div_den   = DIV_DEN_W'(q_job.count);
                        tare_next = q_job.is_tare;
                        st_next   = B_AVG;
                    end else if (slot_free) begin
                        q_pop              = 1'b1;
                        load_out           = 1'b1;
                        out_next           = '0;
                        out_next.sck_level = q_job.sck;
                        out_next.busy_res  = q_job.busy;
                    end
                end
            end
            B_AVG: begin
                if (div_done) begin
                    res_next                = '0;
                    res_next.result_valid   = 1'b1;
                    res_next.result_is_tare = tare_reg;
                    res_next.raw_average    = avg_q;
                    if (tare_reg) begin
                        offset_next = avg_q;
                        st_next     = B_EMIT;
                    end else if (scale_q8 == '0) begin
                        res_next.scale_error = 1'b1;
                        st_next              = B_EMIT;
                    end else begin
                        div_start = 1'b1;
                        div_num   = {1'b0, diff_mag[CODE_BITS-1:0], FRAC_SH'(0)};
                        div_den   = scale_mag;
                        neg_next  = diff[CODE_BITS] ^ scale_q8[CODE_BITS-1];
                        st_next   = B_WT;
                    end
                end
            end
            B_WT: begin
                if (div_done) begin
                    res_next.weight_q8 = neg_reg ? WEIGHT_W'(~div_quo + 1'b1)
                                                 : WEIGHT_W'(div_quo);
                    st_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    out_next = res_reg;
                    st_next  = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
        m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= B_IDLE;
            m_valid_reg <= 1'b0;
            offset_reg  <= '0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
            offset_reg  <= offset_next;
        end
        out_reg  <= out_next;
        res_reg  <= res_next;
        tare_reg <= tare_next;
        neg_reg  <= neg_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = out_reg;

    `LCADC_ASSERT_IMPL(a_pop_has_entry, aclk, aresetn, q_pop, !q_empty)
    `LCADC_ASSERT_IMPL(a_div_start_free, aclk, aresetn, div_start, !div_busy)
    `LCADC_ASSERT_IMPL(a_err_on_measure, aclk, aresetn, m_valid_reg && out_reg.scale_error, out_reg.result_valid && !out_reg.result_is_tare)
    `LCADC_ASSERT_NEXT(a_emit_lands, aclk, aresetn, st_reg == B_EMIT && slot_free, m_valid_reg && out_reg.result_valid)

endmodule

// ===== hw/rtl/load_cell_adc_reader_tare_scale_core.sv =====
// channel   | ports          | payload (lowest bit first)
// ----------+----------------+-------------------------------------------------
// input     | s_t*           | tdata: dt_level; tuser: func
// result    | m_t*           | tdata: sck_level, busy_res, result_valid,
//           |                |        raw_average, weight_q8, scale_error
//           |                | tuser: result_is_tare
// config    | cfg_*          | index 0 avg_count, index 1 scale_q8
//
// a request is taken every cycle while the 4-entry job queue has room; a plain
// tick passes through the job queue and then the output register
// a finishing measurement runs two 41-step serial divides; a finishing tare or
// zero-scale measurement runs one divide
// aresetn is synchronous: clears sequencers, queue and offset, loads default config
// m_tready low holds the result register, then fills the queue, then drops s_tready
module load_cell_adc_reader_tare_scale_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] dt_level
    input  logic [1:0]  s_tuser,   // [1:0] func
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] sck_level, [1] busy_res, [2] result_valid,
                                   // [26:3] raw_average, [67:27] weight_q8,
                                   // [68] scale_error
    output logic [0:0]  m_tuser,   // [0] result_is_tare
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);
    import lcadc_pkg::*;

    logic [CNT_W-1:0]     avg_count_reg;
    logic [CODE_BITS-1:0] scale_q8_reg;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    job_t    push_job;
    job_t    pop_job;
    result_t result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_count_reg <= CNT_W'(1);
            scale_q8_reg  <= CODE_BITS'(256);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_AVG_COUNT: avg_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_SCALE_Q8:  scale_q8_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lcadc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .avg_count (avg_count_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    lcadc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    lcadc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .scale_q8 (scale_q8_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    // pack the result request
    assign m_tdata = {3'b000,
                      result.scale_error,
                      result.weight_q8,
                      result.raw_average,
                      result.result_valid,
                      result.busy_res,
                      result.sck_level};
    assign m_tuser = result.result_is_tare;

endmodule

// ===== tb/load_cell_adc_reader_tare_scale_core_test.sv =====
module load_cell_adc_reader_tare_scale_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcadc_pkg::*;

    // func code with no meaning of its own, behaves as a plain tick
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int RANDOM_REQS = 400;

    // serial link sequencer states of the predictor
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARMED,
        ST_CLK_HIGH,
        ST_CLK_LOW,
        ST_GAIN
    } link_state_e;

    // predicts one result per request and checks the results in order
    class reading_checker;
        logic [7:0]  avg_reg;
        logic [23:0] scale_reg;
        link_state_e state;
        logic [4:0]  bit_cnt;
        logic [23:0] shift_reg;
        logic [7:0]  codes_read;
        logic [30:0] code_total;
        logic [23:0] tare_offset;
        logic        tare_armed;
        result_t     pending_readings[$];
        int          mismatches;

        function new();
            avg_reg     = 8'd1;
            scale_reg   = 24'd256;
            state       = ST_IDLE;
            bit_cnt     = '0;
            shift_reg   = '0;
            codes_read  = '0;
            code_total  = '0;
            tare_offset = '0;
            tare_armed  = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            if (idx == CFG_AVG_COUNT) begin
                avg_reg = val[7:0];
            end else if (idx == CFG_SCALE_Q8) begin
                scale_reg = val;
            end
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        function void note_request(logic [1:0] func, logic dt);
            result_t     r;
            logic [23:0] code;
            logic [7:0]  target;
            longint      diff;
            longint      sc;
            longint      w;
            r = '0;
            case (state)
                ST_IDLE: begin
                    if (func == FUNC_MEASURE || func == FUNC_TARE) begin
                        state      = ST_ARMED;
                        bit_cnt    = '0;
                        shift_reg  = '0;
                        codes_read = '0;
                        code_total = '0;
                        tare_armed = (func == FUNC_TARE);
                    end
                end
                ST_ARMED: begin
                    // converter ready once the data line drops
                    if (!dt) begin
                        state     = ST_CLK_HIGH;
                        bit_cnt   = '0;
                        shift_reg = '0;
                    end
                end
                ST_CLK_HIGH: begin
                    shift_reg = {shift_reg[22:0], dt};
                    bit_cnt   = bit_cnt + 5'd1;
                    state     = ST_CLK_LOW;
                end
                ST_CLK_LOW: begin
                    state = (bit_cnt >= CODE_BITS) ? ST_GAIN : ST_CLK_HIGH;
                end
                default: begin
                    // gain pulse: accumulate the offset-binary code
                    code       = shift_reg ^ SIGN_FLIP;
                    code_total = code_total + code;
                    codes_read = codes_read + 8'd1;
                    target = (avg_reg == 8'd0) ? 8'd1 : (avg_reg > AVG_MAX) ? AVG_MAX : avg_reg;
                    if (codes_read >= target) begin
                        r.result_valid   = 1'b1;
                        r.result_is_tare = tare_armed;
                        r.raw_average    = 24'(code_total / codes_read);
                        if (tare_armed) begin
                            tare_offset = r.raw_average;
                        end else if (scale_reg == 24'd0) begin
                            r.scale_error = 1'b1;
                        end else begin
                            diff = longint'(r.raw_average) - longint'(tare_offset);
                            sc   = longint'($signed(scale_reg));
                            w    = (diff * 64'sd65536) / sc;
                            r.weight_q8 = w[40:0];
                        end
                        state      = ST_IDLE;
                        tare_armed = 1'b0;
                    end else begin
                        state = ST_ARMED;
                    end
                end
            endcase
            r.sck_level = (state == ST_CLK_HIGH || state == ST_GAIN);
            r.busy_res  = (state != ST_IDLE);
            pending_readings.push_back(r);
        endfunction

        function void check_reading(result_t got);
            result_t want;
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: %p", got);
                end
                return;
            end
            want = pending_readings.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch:");
                    $display("  expected sck %0b busy %0b valid %0b tare %0b avg %h weight %0d err %0b",
                             want.sck_level, want.busy_res, want.result_valid,
                             want.result_is_tare, want.raw_average,
                             $signed(want.weight_q8), want.scale_error);
                    $display("  actual   sck %0b busy %0b valid %0b tare %0b avg %h weight %0d err %0b",
                             got.sck_level, got.busy_res, got.result_valid,
                             got.result_is_tare, got.raw_average,
                             $signed(got.weight_q8), got.scale_error);
                end
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = FUNC_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = CFG_AVG_COUNT;
    logic [23:0] cfg_wdata = '0;

    reading_checker sb = new();
    bit gaps_on = 1'b1;
    int gap_pct = 10;
    int reqs_sent = 0;

    load_cell_adc_reader_tare_scale_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("load_cell_adc_reader_tare_scale_core_test NOT OK");
        $finish;
    end

    // result side back-pressure
    initial begin
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (gaps_on) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.sck_level      = m_tdata[0];
            seen.busy_res       = m_tdata[1];
            seen.result_valid   = m_tdata[2];
            seen.raw_average    = m_tdata[26:3];
            seen.weight_q8      = m_tdata[67:27];
            seen.scale_error    = m_tdata[68];
            seen.result_is_tare = m_tuser[0];
            sb.check_reading(seen);
        end
    end

    // func while busy: mostly ticks, sometimes stray starts
    function automatic logic [1:0] stray_func();
        return ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : FUNC_TICK;
    endfunction

    function automatic logic [23:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'h800000;
            2: return 24'h7FFFFF;
            3: return 24'd256;
            4: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    // one request, with an optional gap in front
    task automatic send_req(input logic [1:0] func, input logic dt);
        if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, dt};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, dt);
        reqs_sent++;
    endtask

    // wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // one converter word: busy wait, 24 clocked bits, gain pulse
    task automatic run_conversion(input logic [23:0] raw, input int busy_ticks);
        repeat (busy_ticks) send_req(stray_func(), 1'b1);
        send_req(stray_func(), 1'b0);
        for (int b = CODE_BITS - 1; b >= 0; b--) begin
            send_req(stray_func(), raw[b]);
            send_req(stray_func(), 1'($urandom_range(0, 1)));
        end
        send_req(stray_func(), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int rand_start;
        int codes;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: plain and spare ticks while idle
        send_req(FUNC_TICK, 1'b0);
        send_req(FUNC_TICK, 1'b1);
        send_req(FUNC_SPARE, 1'b0);
        send_req(FUNC_SPARE, 1'b1);
        // measure at default scale, stray starts while armed
        send_req(FUNC_MEASURE, 1'b1);
        run_conversion(24'h7FFFFF, 3);
        // tare at mid-scale, then measure at negative full scale
        send_req(FUNC_TARE, 1'b0);
        run_conversion(24'h000000, 0);
        send_req(FUNC_MEASURE, 1'b1);
        run_conversion(24'h800000, 1);

        // zero scale flags an error
        drain();
        write_reg(CFG_SCALE_Q8, 24'd0);
        send_req(FUNC_MEASURE, 1'b0);
        run_conversion(24'h7FFFFF, 0);
        // scale extremes
        drain();
        write_reg(CFG_SCALE_Q8, 24'h800000);
        send_req(FUNC_MEASURE, 1'b0);
        run_conversion(24'h7FFFFF, 0);
        drain();
        write_reg(CFG_SCALE_Q8, 24'h7FFFFF);
        send_req(FUNC_MEASURE, 1'b0);
        run_conversion(24'h800000, 2);
        // zero offset, then largest weights of both signs
        send_req(FUNC_TARE, 1'b1);
        run_conversion(24'h800000, 0);
        drain();
        write_reg(CFG_SCALE_Q8, 24'hFFFFFF);
        send_req(FUNC_MEASURE, 1'b0);
        run_conversion(24'h7FFFFF, 0);
        drain();
        write_reg(CFG_SCALE_Q8, 24'd1);
        send_req(FUNC_MEASURE, 1'b0);
        run_conversion(24'h7FFFFF, 0);

        // count zero acts as one
        drain();
        write_reg(CFG_AVG_COUNT, 24'd0);
        write_reg(CFG_SCALE_Q8, 24'd256);
        send_req(FUNC_MEASURE, 1'b0);
        run_conversion(pick_raw(), 1);
        // count above the cap, lowered while the measurement runs
        drain();
        write_reg(CFG_AVG_COUNT, 24'd255);
        send_req(FUNC_MEASURE, 1'b0);
        run_conversion(pick_raw(), 0);
        run_conversion(pick_raw(), 1);
        drain();
        write_reg(CFG_AVG_COUNT, 24'd2);
        run_conversion(pick_raw(), 0);
        // average of several largest codes
        drain();
        write_reg(CFG_AVG_COUNT, 24'd3);
        send_req(FUNC_MEASURE, 1'b0);
        repeat (3) run_conversion(24'h7FFFFF, 0);

        // random phases: mostly well-formed operations, some noise
        rand_start = reqs_sent;
        while (reqs_sent - rand_start < RANDOM_REQS) begin
            drain();
            codes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 1;
            write_reg(CFG_AVG_COUNT, 24'(codes));
            write_reg(CFG_SCALE_Q8, pick_scale());
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 5;
                default: gap_pct = 25;
            endcase
            repeat ($urandom_range(3, 8)) begin
                if (reqs_sent - rand_start > RANDOM_REQS * 3 / 4) begin
                    gaps_on = 1'b0;
                end
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(5, 40)) begin
                        send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                    end
                end else begin
                    // finish whatever the noise started
                    while (sb.state != ST_IDLE) begin
                        send_req(stray_func(), 1'($urandom_range(0, 1)));
                    end
                    repeat ($urandom_range(0, 3)) begin
                        send_req($urandom_range(0, 1) ? FUNC_SPARE : FUNC_TICK,
                                 1'($urandom_range(0, 1)));
                    end
                    send_req($urandom_range(0, 2) == 0 ? FUNC_TARE : FUNC_MEASURE,
                             1'($urandom_range(0, 1)));
                    repeat ((codes == 0) ? 1 : codes) run_conversion(pick_raw(), $urandom_range(0, 3));
                end
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("load_cell_adc_reader_tare_scale_core_test OK");
        end else begin
            $display("load_cell_adc_reader_tare_scale_core_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lcadc_pkg.sv
hw/rtl/lcadc_div.sv
hw/rtl/lcadc_fifo.sv
hw/rtl/lcadc_front.sv
hw/rtl/lcadc_back.sv
hw/rtl/load_cell_adc_reader_tare_scale_core.sv
tb/load_cell_adc_reader_tare_scale_core_test.sv
